/* sv/blackman_window_applier_unit_assert.svh */
// ----------------------------------------------------------------------------
// Blackman window applier assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BLACKMAN_WINDOW_APPLIER_UNIT_ASSERT_SVH
`define BLACKMAN_WINDOW_APPLIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BWA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bwa assertion failed");

// Next-cycle implication, disabled during reset
`define BWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bwa assertion failed");

`endif

/* sv/bwa_pkg.sv */
// ----------------------------------------------------------------------------
// bwa_pkg
// Constants, types, microcode codes and the quarter-wave cosine ROM.
// ----------------------------------------------------------------------------
package bwa_pkg;

    // Widths
    localparam int SAMPLE_BITS   = 24;
    localparam int MAX_LENGTH    = 4096;
    localparam int POS_BITS      = 12;
    localparam int LEN_BITS      = 13;
    localparam int PHASE_BITS    = 24;
    localparam int COS_DEPTH     = 1024;
    localparam int COS_IDX_BITS  = $clog2(COS_DEPTH);
    localparam int ROM_DEPTH     = COS_DEPTH / 4;
    localparam int ROM_IDX_BITS  = $clog2(ROM_DEPTH);
    localparam int FRAC_BITS     = 17;
    localparam int COEF_BITS     = FRAC_BITS + 1;      // 0 .. 2^17
    localparam int COS_BITS      = FRAC_BITS + 2;      // signed -2^17 .. 2^17
    localparam int ACC_BITS      = 37;
    localparam int MUL_A_BITS    = SAMPLE_BITS + 1;
    localparam int MUL_B_BITS    = COS_BITS;
    localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
    localparam int DVD_BITS      = SAMPLE_BITS + FRAC_BITS;
    localparam int CNT_BITS      = $clog2(SAMPLE_BITS);
    localparam int STEP_BITS     = 4;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 24;

    // Coefficients, Q1.17
    localparam int Q17_ONE = 131072;
    localparam int COEF_A  = 55914;
    localparam int COEF_B  = 65085;
    localparam int COEF_C  = 10073;
    localparam longint ACC_BIAS = longint'(COEF_A) * longint'(Q17_ONE);

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_WINDOW_LENGTH = 3'd0,
        CFG_PHASE_STEP    = 3'd1,
        CFG_START_INDEX   = 3'd2,
        CFG_INVERT_WINDOW = 3'd3,
        CFG_DIVIDE_MODE   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_BITS-1:0]   window_length;
        logic [PHASE_BITS-1:0] phase_step;
        logic [POS_BITS-1:0]   start_index;
        logic                  invert_window;
        logic                  divide_mode;
    } t_cfg;

    // Datapath operations driven by the microcode
    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_ACCEPT = 4'd1,
        OP_PHASE  = 4'd2,
        OP_COS1   = 4'd3,
        OP_COS2   = 4'd4,
        OP_TERMB  = 4'd5,
        OP_TERMC  = 4'd6,
        OP_COEF   = 4'd7,
        OP_MUL    = 4'd8,
        OP_DSETUP = 4'd9,
        OP_DITER  = 4'd10,
        OP_DFIN   = 4'd11,
        OP_OUT    = 4'd12
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        CND_NEXT    = 3'd0,
        CND_ALWAYS  = 3'd1,
        CND_DIVIDE  = 3'd2,
        CND_SPECIAL = 3'd3,
        CND_COUNT   = 3'd4
    } t_cond;

    typedef struct packed {
        t_op                  op;
        t_cond                cond;
        logic [STEP_BITS-1:0] target;
        logic                 hold_in;
        logic                 hold_out;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic divide;
        logic special;
        logic count_nz;
    } t_stat;

    // Quarter-wave cosine magnitudes, entry m-1 holds cos at m/COS_DEPTH turn
    typedef logic [ROM_DEPTH-1:0][COEF_BITS-1:0] t_cos_rom;

    function automatic logic [COEF_BITS-1:0] cos_poly(input int unsigned m);
        longint s;
        longint z;
        longint p;
        s = longint'(m) <<< (30 - ROM_IDX_BITS);
        z = (s * s) >>> 30;
        p = 27060;
        p = 987048 - ((p * z) >>> 30);
        p = 22401992 - ((p * z) >>> 30);
        p = 272375560 - ((p * z) >>> 30);
        p = 1324675879 - ((p * z) >>> 30);
        p = (longint'(1) <<< 30) - ((p * z) >>> 30);
        if (p < 0) begin
            p = 0;
        end
        p = (p + 4096) >>> 13;
        return p[COEF_BITS-1:0];
    endfunction

    function automatic t_cos_rom build_cos_rom();
        t_cos_rom rom;
        rom = '0;
        for (int m = 1; m <= ROM_DEPTH; m++) begin
            rom[m-1] = cos_poly(m);
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos_rom();

endpackage

/* sv/bwa_seq.sv */
// ----------------------------------------------------------------------------
// bwa_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module bwa_seq import bwa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    localparam logic [STEP_BITS-1:0] ST_ACCEPT = 4'd0;
    localparam logic [STEP_BITS-1:0] ST_PHASE  = 4'd1;
    localparam logic [STEP_BITS-1:0] ST_COS1   = 4'd2;
    localparam logic [STEP_BITS-1:0] ST_COS2   = 4'd3;
    localparam logic [STEP_BITS-1:0] ST_TERMB  = 4'd4;
    localparam logic [STEP_BITS-1:0] ST_TERMC  = 4'd5;
    localparam logic [STEP_BITS-1:0] ST_COEF   = 4'd6;
    localparam logic [STEP_BITS-1:0] ST_MUL    = 4'd7;
    localparam logic [STEP_BITS-1:0] ST_DSETUP = 4'd8;
    localparam logic [STEP_BITS-1:0] ST_DITER  = 4'd9;
    localparam logic [STEP_BITS-1:0] ST_DFIN   = 4'd10;
    localparam logic [STEP_BITS-1:0] ST_OUT    = 4'd11;

    // Control program
    function automatic t_uword ucode(input logic [STEP_BITS-1:0] a);
        t_uword w;
        w = '{op: OP_NOP, cond: CND_ALWAYS, target: ST_ACCEPT, hold_in: 1'b0, hold_out: 1'b0};
        unique case (a)
            ST_ACCEPT: w = '{OP_ACCEPT, CND_NEXT,    ST_ACCEPT, 1'b1, 1'b0};
            ST_PHASE:  w = '{OP_PHASE,  CND_NEXT,    ST_ACCEPT, 1'b0, 1'b0};
            ST_COS1:   w = '{OP_COS1,   CND_NEXT,    ST_ACCEPT, 1'b0, 1'b0};
            ST_COS2:   w = '{OP_COS2,   CND_NEXT,    ST_ACCEPT, 1'b0, 1'b0};
            ST_TERMB:  w = '{OP_TERMB,  CND_NEXT,    ST_ACCEPT, 1'b0, 1'b0};
            ST_TERMC:  w = '{OP_TERMC,  CND_NEXT,    ST_ACCEPT, 1'b0, 1'b0};
            ST_COEF:   w = '{OP_COEF,   CND_DIVIDE,  ST_DSETUP, 1'b0, 1'b0};
            ST_MUL:    w = '{OP_MUL,    CND_ALWAYS,  ST_OUT,    1'b0, 1'b0};
            ST_DSETUP: w = '{OP_DSETUP, CND_SPECIAL, ST_DFIN,   1'b0, 1'b0};
            ST_DITER:  w = '{OP_DITER,  CND_COUNT,   ST_DITER,  1'b0, 1'b0};
            ST_DFIN:   w = '{OP_DFIN,   CND_NEXT,    ST_ACCEPT, 1'b0, 1'b0};
            ST_OUT:    w = '{OP_OUT,    CND_ALWAYS,  ST_ACCEPT, 1'b0, 1'b1};
            default:   w = '{OP_NOP,    CND_ALWAYS,  ST_ACCEPT, 1'b0, 1'b0};
        endcase
        return w;
    endfunction

    logic [STEP_BITS-1:0] r_step;
    logic [STEP_BITS-1:0] n_step;
    t_uword               uw;
    logic                 stall;
    logic                 take;

    assign uw = ucode(r_step);

    // Hold the step while waiting on either channel
    assign stall = (uw.hold_in & ~i_stat.in_valid) | (uw.hold_out & i_stat.out_busy);

    // Jump condition
    always_comb begin
        case (uw.cond)
            CND_NEXT:    take = 1'b0;
            CND_ALWAYS:  take = 1'b1;
            CND_DIVIDE:  take = i_stat.divide;
            CND_SPECIAL: take = i_stat.special;
            CND_COUNT:   take = i_stat.count_nz;
            default:     take = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            n_step = r_step;
        end else if (take) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_ACCEPT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.op   = uw.op;
    assign o_ctrl.fire = ~stall;

endmodule

/* sv/bwa_datapath.sv */
// ----------------------------------------------------------------------------
// bwa_datapath
// Position counter, cosine lookup, shared multiplier and radix-2 divider.
// ----------------------------------------------------------------------------
module bwa_datapath import bwa_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctrl                         i_ctrl,
    input  t_cfg                          i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_frame_end,
    output logic                          o_special,
    output logic                          o_count_nz,
    output logic signed [SAMPLE_BITS-1:0] o_result,
    output logic                          o_sat,
    output logic                          o_fend
);

    logic                          r_fend;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [POS_BITS-1:0]           r_pos;
    logic [PHASE_BITS-1:0]         r_phase;
    logic signed [COS_BITS-1:0]    r_cos1;
    logic signed [COS_BITS-1:0]    r_cos2;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic [COEF_BITS-1:0]          r_coef;
    logic [COEF_BITS-1:0]          r_rem;
    logic [SAMPLE_BITS-1:0]        r_dvd;
    logic [SAMPLE_BITS-1:0]        r_quo;
    logic [CNT_BITS-1:0]           r_cnt;
    logic                          r_special;
    logic signed [SAMPLE_BITS-1:0] r_result;
    logic                          r_sat;

    logic fire_op;
    assign fire_op = i_ctrl.fire;

    // ---- cosine lookup with quarter-wave symmetry ----
    logic [PHASE_BITS-1:0]     tbl_phase;
    logic [COS_IDX_BITS-1:0]   tbl_k;
    logic [COS_IDX_BITS-1:0]   tbl_half;
    logic [COS_IDX_BITS-1:0]   tbl_m;
    logic                      tbl_neg;
    logic [COEF_BITS-1:0]      tbl_mag;
    logic signed [COS_BITS-1:0] tbl_cos;

    assign tbl_phase = (i_ctrl.op == OP_COS2) ? {r_phase[PHASE_BITS-2:0], 1'b0} : r_phase;
    assign tbl_k     = tbl_phase[PHASE_BITS-1 -: COS_IDX_BITS];
    // fold second half of the turn onto the first
    assign tbl_half  = tbl_k[COS_IDX_BITS-1]
                     ? COS_IDX_BITS'((COS_IDX_BITS+1)'(COS_DEPTH) - {1'b0, tbl_k}) : tbl_k;
    assign tbl_neg   = tbl_half > COS_IDX_BITS'(ROM_DEPTH);
    assign tbl_m     = tbl_neg ? COS_IDX_BITS'(COS_DEPTH / 2) - tbl_half : tbl_half;
    assign tbl_mag   = (tbl_m == '0) ? COEF_BITS'(Q17_ONE)
                     : COS_ROM[ROM_IDX_BITS'(tbl_m - 1'b1)];
    assign tbl_cos   = tbl_neg ? -$signed({1'b0, tbl_mag}) : $signed({1'b0, tbl_mag});

    // ---- shared multiplier ----
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [PROD_BITS-1:0]  prod;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.op)
            OP_PHASE: begin
                mul_a = $signed({1'b0, i_cfg.phase_step});
                mul_b = $signed(MUL_B_BITS'(r_pos));
            end
            OP_TERMB: begin
                mul_a = $signed(MUL_A_BITS'(COEF_B));
                mul_b = r_cos1;
            end
            OP_TERMC: begin
                mul_a = $signed(MUL_A_BITS'(COEF_C));
                mul_b = r_cos2;
            end
            OP_MUL: begin
                mul_a = MUL_A_BITS'(r_sample);
                mul_b = $signed({1'b0, r_coef});
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // ---- coefficient rounding, clamp and optional inversion ----
    logic signed [ACC_BITS-1:0] acc_rnd;
    logic [COEF_BITS-1:0]       w_raw;
    logic [COEF_BITS-1:0]       w_fin;

    assign acc_rnd = r_acc + ACC_BITS'(65536);
    always_comb begin
        if (r_acc < 0) begin
            w_raw = '0;
        end else if (acc_rnd[ACC_BITS-1:FRAC_BITS] > (ACC_BITS-FRAC_BITS)'(Q17_ONE)) begin
            w_raw = COEF_BITS'(Q17_ONE);
        end else begin
            w_raw = acc_rnd[FRAC_BITS +: COEF_BITS];
        end
    end
    assign w_fin = i_cfg.invert_window ? COEF_BITS'(Q17_ONE) - w_raw : w_raw;

    // ---- multiply mode rounding and saturation ----
    logic signed [PROD_BITS-1:0]           prod_rnd;
    logic signed [PROD_BITS-FRAC_BITS-1:0] mul_r;
    logic signed [SAMPLE_BITS-1:0]         mul_res;
    logic                                  mul_sat;

    assign prod_rnd = prod + PROD_BITS'(65536);
    assign mul_r    = prod_rnd[PROD_BITS-1:FRAC_BITS];
    always_comb begin
        if (mul_r > (PROD_BITS-FRAC_BITS)'(S_MAX)) begin
            mul_res = S_MAX;
            mul_sat = 1'b1;
        end else if (mul_r < (PROD_BITS-FRAC_BITS)'(S_MIN)) begin
            mul_res = S_MIN;
            mul_sat = 1'b1;
        end else begin
            mul_res = SAMPLE_BITS'(mul_r);
            mul_sat = 1'b0;
        end
    end

    // ---- divide setup: dividend, overflow and zero-coefficient check ----
    logic [SAMPLE_BITS-1:0] s_mag;
    logic [DVD_BITS-1:0]    dvd;
    logic                   dvd_ovf;

    assign s_mag   = r_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_sample) : r_sample;
    assign dvd     = {s_mag, {FRAC_BITS{1'b0}}} + DVD_BITS'(r_coef >> 1);
    assign dvd_ovf = {1'b0, dvd} >= {r_coef, {SAMPLE_BITS{1'b0}}};
    assign o_special = (r_coef == '0) | dvd_ovf;

    // ---- one restoring division step ----
    logic [COEF_BITS:0] div_rr;
    logic               div_ge;
    assign div_rr = {r_rem, r_dvd[SAMPLE_BITS-1]};
    assign div_ge = div_rr >= {1'b0, r_coef};

    // ---- divide finish: sign and saturation ----
    logic signed [SAMPLE_BITS-1:0] div_res;
    logic                          div_sat;
    always_comb begin
        div_res = '0;
        div_sat = 1'b0;
        if (r_special) begin
            if (r_sample != '0) begin
                div_res = r_sample[SAMPLE_BITS-1] ? S_MIN : S_MAX;
                div_sat = 1'b1;
            end
        end else if (r_sample[SAMPLE_BITS-1]) begin
            if (r_quo > S_MIN) begin
                div_res = S_MIN;
                div_sat = 1'b1;
            end else begin
                div_res = $signed(-r_quo);
            end
        end else begin
            if (r_quo > S_MAX) begin
                div_res = S_MAX;
                div_sat = 1'b1;
            end else begin
                div_res = $signed(r_quo);
            end
        end
    end

    // ---- next window position ----
    logic [LEN_BITS-1:0] len_eff;
    logic [LEN_BITS-1:0] pos_inc;
    logic [POS_BITS-1:0] pos_next;
    assign len_eff = (i_cfg.window_length > LEN_BITS'(MAX_LENGTH))
                   ? LEN_BITS'(MAX_LENGTH) : i_cfg.window_length;
    assign pos_inc = {1'b0, r_pos} + 1'b1;
    always_comb begin
        if (r_fend) begin
            pos_next = i_cfg.start_index;
        end else if (len_eff < LEN_BITS'(2) || pos_inc >= len_eff - 1'b1) begin
            pos_next = '0;
        end else begin
            pos_next = pos_inc[POS_BITS-1:0];
        end
    end

    // Position is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (fire_op && i_ctrl.op == OP_OUT) begin
            r_pos <= pos_next;
        end
    end

    // Payload registers, one operation per step
    always_ff @(posedge i_clk) begin
        if (fire_op) begin
            case (i_ctrl.op)
                OP_ACCEPT: begin
                    r_sample <= i_sample_in;
                    r_fend   <= i_frame_end;
                end
                OP_PHASE:  r_phase <= prod[PHASE_BITS-1:0];
                OP_COS1:   r_cos1  <= tbl_cos;
                OP_COS2:   r_cos2  <= tbl_cos;
                OP_TERMB:  r_acc   <= ACC_BITS'(ACC_BIAS) - ACC_BITS'(prod);
                OP_TERMC:  r_acc   <= r_acc + ACC_BITS'(prod);
                OP_COEF:   r_coef  <= w_fin;
                OP_MUL: begin
                    r_result <= mul_res;
                    r_sat    <= mul_sat;
                end
                OP_DSETUP: begin
                    r_special <= o_special;
                    r_rem     <= COEF_BITS'(dvd[DVD_BITS-1:SAMPLE_BITS]);
                    r_dvd     <= dvd[SAMPLE_BITS-1:0];
                    r_quo     <= '0;
                    r_cnt     <= CNT_BITS'(SAMPLE_BITS - 1);
                end
                OP_DITER: begin
                    r_rem <= div_ge ? COEF_BITS'(div_rr - {1'b0, r_coef}) : COEF_BITS'(div_rr);
                    r_quo <= {r_quo[SAMPLE_BITS-2:0], div_ge};
                    r_dvd <= {r_dvd[SAMPLE_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                end
                OP_DFIN: begin
                    r_result <= div_res;
                    r_sat    <= div_sat;
                end
                default: ;
            endcase
        end
    end

    assign o_count_nz = (r_cnt != '0);
    assign o_result   = r_result;
    assign o_sat      = r_sat;
    assign o_fend     = r_fend;

endmodule

/* sv/blackman_window_applier_unit.sv */
// ----------------------------------------------------------------------------
// blackman_window_applier_unit
// Applies (or removes) a three-term Blackman window to a Q1.23 sample stream.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_ready | i_sample_in, i_frame_end
//  out      | output    | o_out_valid/i_out_ready | o_sample_out, o_saturated,
//           |           |                         | o_frame_end_out
//  cfg      | input     | i_cfg_we                | i_cfg_addr, i_cfg_wdata
//
//  Multiply mode and divide mode run on the microcode sequencer and its shared
//  multiplier; the divider loop yields 24 quotient bits, one per cycle, and is
//  skipped when the coefficient is zero or the quotient would overflow.
//  Reset is synchronous, active low; position returns to 0, no clearing pass.
//  A result waits in the output register; the next item is taken meanwhile
//  and its own result waits only if that register is still full.
// ----------------------------------------------------------------------------
`include "blackman_window_applier_unit_assert.svh"

module blackman_window_applier_unit import bwa_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_frame_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_saturated,
    output logic                          o_frame_end_out,
    input  logic                          i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]      i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_wdata
);

    t_cfg  r_cfg;
    t_ctrl ctrl;
    t_stat stat;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_sat;
    logic                          r_out_fend;

    logic                          dp_special;
    logic                          dp_count_nz;
    logic signed [SAMPLE_BITS-1:0] dp_result;
    logic                          dp_sat;
    logic                          dp_fend;
    logic                          out_load;
    logic                          out_full_scale;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length <= LEN_BITS'(1024);
            r_cfg.phase_step    <= PHASE_BITS'(16400);
            r_cfg.start_index   <= '0;
            r_cfg.invert_window <= 1'b0;
            r_cfg.divide_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WINDOW_LENGTH: r_cfg.window_length <= i_cfg_wdata[LEN_BITS-1:0];
                CFG_PHASE_STEP:    r_cfg.phase_step    <= i_cfg_wdata[PHASE_BITS-1:0];
                CFG_START_INDEX:   r_cfg.start_index   <= i_cfg_wdata[POS_BITS-1:0];
                CFG_INVERT_WINDOW: r_cfg.invert_window <= i_cfg_wdata[0];
                CFG_DIVIDE_MODE:   r_cfg.divide_mode   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Status into the sequencer
    assign stat.in_valid = i_in_valid;
    assign stat.out_busy = r_out_valid & ~i_out_ready;
    assign stat.divide   = r_cfg.divide_mode;
    assign stat.special  = dp_special;
    assign stat.count_nz = dp_count_nz;

    bwa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    bwa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_cfg       (r_cfg),
        .i_sample_in (i_sample_in),
        .i_frame_end (i_frame_end),
        .o_special   (dp_special),
        .o_count_nz  (dp_count_nz),
        .o_result    (dp_result),
        .o_sat       (dp_sat),
        .o_fend      (dp_fend)
    );

    // no item is taken while reset is held
    assign o_in_ready = i_rst_n && (ctrl.op == OP_ACCEPT);
    assign out_load   = ctrl.fire && (ctrl.op == OP_OUT);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= dp_result;
            r_out_sat    <= dp_sat;
            r_out_fend   <= dp_fend;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_out_sample;
    assign o_saturated     = r_out_sat;
    assign o_frame_end_out = r_out_fend;

    assign out_full_scale = (o_sample_out == S_MAX) || (o_sample_out == S_MIN);

    // Checks
    `BWA_ASSERT_NEXT(a_accept_moves_on, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `BWA_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, out_load, !r_out_valid || i_out_ready)
    `BWA_ASSERT_SAME(a_sat_full_scale, i_clk, i_rst_n, o_out_valid && o_saturated, out_full_scale)

endmodule
